/* src/fdsa_pkg.sv */
// Shared types and constants for the data stack ALU.
// No dependencies; used by fdsa_muldiv and forth_data_stack_alu_core.
`timescale 1ns / 1ps
package fdsa_pkg;

   localparam int WORD_W          = 32;
   localparam int STACK_DEPTH_DEF = 32;
   localparam int MEM_WORDS_DEF   = 256;
   localparam int STEP_W          = $clog2(WORD_W);

   typedef enum logic [3:0] {
      OP_PUSH  = 4'd0,
      OP_ADD   = 4'd1,
      OP_SUB   = 4'd2,
      OP_MUL   = 4'd3,
      OP_DIV   = 4'd4,
      OP_DUP   = 4'd5,
      OP_DROP  = 4'd6,
      OP_SWAP  = 4'd7,
      OP_ROT   = 4'd8,
      OP_EQ    = 4'd9,
      OP_GT    = 4'd10,
      OP_LT    = 4'd11,
      OP_AND   = 4'd12,
      OP_NOT   = 4'd13,
      OP_FETCH = 4'd14,
      OP_STORE = 4'd15
   } opcode_type;

   typedef enum logic [2:0] {
      ST_OK    = 3'd0,
      ST_UNDER = 3'd1,
      ST_OVER  = 3'd2,
      ST_DIV0  = 3'd3,
      ST_ADDR  = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_RD_T,
      S_RD_S,
      S_RD_A,
      S_EXEC,
      S_MULDIV,
      S_WR0,
      S_WR1,
      S_WR2,
      S_RD_TOP,
      S_RESP
   } state_type;

endpackage

/* src/fdsa_muldiv.sv */
// Shared iterative multiply / truncating divide unit, one bit per cycle.
// Depends on fdsa_pkg.
`timescale 1ns / 1ps
module fdsa_muldiv (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       go,
   input  logic                       is_div,
   input  logic [fdsa_pkg::WORD_W-1:0] op_a,
   input  logic [fdsa_pkg::WORD_W-1:0] op_b,
   output logic                       done,
   output logic [fdsa_pkg::WORD_W-1:0] result
);

   localparam int W = fdsa_pkg::WORD_W;

   logic                              run_ff, run_in;
   logic                              done_ff, done_in;
   logic                              div_ff, div_in;
   logic                              neg_ff, neg_in;
   logic [fdsa_pkg::STEP_W-1:0]       cnt_ff, cnt_in;
   logic [W-1:0]                      acc_ff, acc_in;
   logic [W-1:0]                      x_ff, x_in;
   logic [W-1:0]                      y_ff, y_in;
   logic [W:0]                        rem_sh;
   logic [W:0]                        diff;

   // one step of shift-add or restoring divide
   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      div_in  = div_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      rem_sh  = {acc_ff, x_ff[W-1]};
      diff    = rem_sh - {1'b0, y_ff};
      if (go) begin
         run_in = 1'b1;
         div_in = is_div;
         neg_in = is_div & (op_a[W-1] ^ op_b[W-1]);
         cnt_in = '0;
         acc_in = '0;
         x_in   = (is_div && op_a[W-1]) ? (W'(0) - op_a) : op_a;
         y_in   = (is_div && op_b[W-1]) ? (W'(0) - op_b) : op_b;
      end else if (run_ff) begin
         if (div_ff) begin
            if (!diff[W]) begin
               acc_in = diff[W-1:0];
               x_in   = {x_ff[W-2:0], 1'b1};
            end else begin
               acc_in = rem_sh[W-1:0];
               x_in   = {x_ff[W-2:0], 1'b0};
            end
         end else begin
            if (y_ff[0]) acc_in = acc_ff + x_ff;
            x_in = {x_ff[W-2:0], 1'b0};
            y_in = {1'b0, y_ff[W-1:1]};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == fdsa_pkg::STEP_W'(W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      div_ff <= div_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
   end

   assign done   = done_ff;
   assign result = !div_ff ? acc_ff : (neg_ff ? (W'(0) - x_ff) : x_ff);

   // unit never reports done while still stepping
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !run_ff) else $error("muldiv done while running");
   // done only rises after the unit has been stepping
   a_run_len: assert property (@(posedge clock) disable iff (reset)
      $rose(done_ff) |-> $past(run_ff)) else $error("muldiv done without run");
   a_no_go_busy: assert property (@(posedge clock) disable iff (reset)
      go |-> !run_ff) else $error("muldiv started while busy");

endmodule

/* src/forth_data_stack_alu_core.sv */
// Forth data stack ALU: a taken word reads the stack (S_RD_T, S_RD_S, S_RD_A), executes
// in S_EXEC, waits in S_MULDIV on the shared one-bit-per-cycle unit for mul and div,
// makes up to three stack writes (S_WR0, S_WR1, S_WR2), reads the new top in S_RD_TOP
// and strobes the result in S_RESP. One word at a time: busy stays high through the
// strobe and drops when the core is back in idle. The stack memory's single read and
// single write port make reads and writes go one per state. Synchronous reset empties
// the stack; S_CLEAR then clears the word memory, busy high. Results cannot be stalled.
// Depends on fdsa_pkg and fdsa_muldiv.
`timescale 1ns / 1ps
module forth_data_stack_alu_core #(
   parameter int STACK_DEPTH = fdsa_pkg::STACK_DEPTH_DEF,
   parameter int MEM_WORDS   = fdsa_pkg::MEM_WORDS_DEF,
   localparam int DW = $clog2(STACK_DEPTH + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [3:0]            req_opcode,
   input  logic signed [31:0]    req_literal,
   output logic                  rsp_strobe,
   output logic signed [31:0]    rsp_top_value,
   output logic [DW-1:0]         rsp_stack_depth,
   output logic [2:0]            rsp_status,
   output logic signed [31:0]    rsp_popped_value,
   output logic                  rsp_popped_valid
);

   localparam int W   = fdsa_pkg::WORD_W;
   localparam int SAW = $clog2(STACK_DEPTH);
   localparam int AW  = $clog2(MEM_WORDS);

   fdsa_pkg::state_type   state_ff, state_in;
   fdsa_pkg::opcode_type  op_ff, op_in;
   fdsa_pkg::status_type  status_ff, status_in;
   logic [W-1:0]          lit_ff, lit_in;
   logic [DW-1:0]         depth_ff, depth_in;
   logic [W-1:0]          t_ff, t_in;
   logic [W-1:0]          s_ff, s_in;
   logic [W-1:0]          popped_ff, popped_in;
   logic                  popped_valid_ff, popped_valid_in;
   logic [1:0]            wnum_ff, wnum_in;
   logic [SAW-1:0]        waddr_ff [3];
   logic [SAW-1:0]        waddr_in [3];
   logic [W-1:0]          wdata_ff [3];
   logic [W-1:0]          wdata_in [3];
   logic [AW-1:0]         clr_ff, clr_in;

   // stack memory
   logic [W-1:0]          stk_mem [STACK_DEPTH];
   logic [W-1:0]          stk_rdata_ff;
   logic [SAW-1:0]        stk_raddr;
   logic                  stk_we;
   logic [SAW-1:0]        stk_waddr;
   logic [W-1:0]          stk_wdata;

   // word memory
   logic [W-1:0]          word_mem [MEM_WORDS];
   logic [W-1:0]          mem_rdata_ff;
   logic                  mem_we;
   logic [AW-1:0]         mem_waddr;
   logic [W-1:0]          mem_wdata;

   // execute-stage decode
   logic [1:0]            need;
   logic                  grow;
   fdsa_pkg::status_type  exe_status;
   logic                  md_go;
   logic                  md_done;
   logic [W-1:0]          md_result;

   fdsa_muldiv u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .go     (md_go),
      .is_div (op_ff == fdsa_pkg::OP_DIV),
      .op_a   (s_ff),
      .op_b   (t_ff),
      .done   (md_done),
      .result (md_result)
   );

   // operand count and growth per opcode
   always_comb begin
      unique case (op_ff) inside
         fdsa_pkg::OP_PUSH: begin
            need = 2'd0; grow = 1'b1;
         end
         fdsa_pkg::OP_DUP: begin
            need = 2'd1; grow = 1'b1;
         end
         fdsa_pkg::OP_DROP, fdsa_pkg::OP_NOT, fdsa_pkg::OP_FETCH: begin
            need = 2'd1; grow = 1'b0;
         end
         fdsa_pkg::OP_ROT: begin
            need = 2'd3; grow = 1'b0;
         end
         fdsa_pkg::OP_EQ, fdsa_pkg::OP_GT, fdsa_pkg::OP_LT: begin
            need = 2'd2; grow = 1'b1;
         end
         default: begin
            need = 2'd2; grow = 1'b0;
         end
      endcase
   end

   // status priority: underflow, overflow, then operand checks
   always_comb begin
      if (depth_ff < DW'(need))
         exe_status = fdsa_pkg::ST_UNDER;
      else if (grow && depth_ff >= DW'(STACK_DEPTH))
         exe_status = fdsa_pkg::ST_OVER;
      else if (op_ff == fdsa_pkg::OP_DIV && t_ff == '0)
         exe_status = fdsa_pkg::ST_DIV0;
      else if ((op_ff == fdsa_pkg::OP_FETCH || op_ff == fdsa_pkg::OP_STORE)
               && t_ff >= W'(MEM_WORDS))
         exe_status = fdsa_pkg::ST_ADDR;
      else
         exe_status = fdsa_pkg::ST_OK;
   end

   // sequencer: next state and datapath
   always_comb begin
      logic [DW-1:0] dm1, dm2, dm3;
      dm1 = depth_ff - DW'(1);
      dm2 = depth_ff - DW'(2);
      dm3 = depth_ff - DW'(3);

      state_in        = state_ff;
      op_in           = op_ff;
      lit_in          = lit_ff;
      status_in       = status_ff;
      depth_in        = depth_ff;
      t_in            = t_ff;
      s_in            = s_ff;
      popped_in       = popped_ff;
      popped_valid_in = popped_valid_ff;
      wnum_in         = wnum_ff;
      waddr_in        = waddr_ff;
      wdata_in        = wdata_ff;
      clr_in          = clr_ff;
      md_go           = 1'b0;
      stk_raddr       = dm1[SAW-1:0];
      stk_we          = 1'b0;
      stk_waddr       = waddr_ff[0];
      stk_wdata       = wdata_ff[0];
      mem_we          = 1'b0;
      mem_waddr       = t_ff[AW-1:0];
      mem_wdata       = s_ff;

      unique case (state_ff)
         fdsa_pkg::S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == AW'(MEM_WORDS - 1)) state_in = fdsa_pkg::S_IDLE;
         end
         fdsa_pkg::S_IDLE: begin
            if (start) begin
               op_in    = fdsa_pkg::opcode_type'(req_opcode);
               lit_in   = req_literal;
               state_in = fdsa_pkg::S_RD_T;
            end
         end
         fdsa_pkg::S_RD_T: begin
            stk_raddr = dm1[SAW-1:0];
            state_in  = fdsa_pkg::S_RD_S;
         end
         fdsa_pkg::S_RD_S: begin
            t_in      = stk_rdata_ff;
            stk_raddr = dm2[SAW-1:0];
            state_in  = fdsa_pkg::S_RD_A;
         end
         fdsa_pkg::S_RD_A: begin
            s_in      = stk_rdata_ff;
            stk_raddr = dm3[SAW-1:0];
            state_in  = fdsa_pkg::S_EXEC;
         end
         fdsa_pkg::S_EXEC: begin
            status_in       = exe_status;
            popped_in       = '0;
            popped_valid_in = 1'b0;
            wnum_in         = 2'd0;
            waddr_in[0]     = dm2[SAW-1:0];
            waddr_in[1]     = dm2[SAW-1:0];
            waddr_in[2]     = dm1[SAW-1:0];
            wdata_in[0]     = '0;
            wdata_in[1]     = t_ff;
            wdata_in[2]     = stk_rdata_ff;
            if (exe_status == fdsa_pkg::ST_OK) begin
               unique case (op_ff)
                  fdsa_pkg::OP_PUSH: begin
                     wnum_in = 2'd1; waddr_in[0] = depth_ff[SAW-1:0];
                     wdata_in[0] = lit_ff; depth_in = depth_ff + DW'(1);
                  end
                  fdsa_pkg::OP_ADD: begin
                     wnum_in = 2'd1; wdata_in[0] = s_ff + t_ff; depth_in = dm1;
                  end
                  fdsa_pkg::OP_SUB: begin
                     wnum_in = 2'd1; wdata_in[0] = s_ff - t_ff; depth_in = dm1;
                  end
                  fdsa_pkg::OP_AND: begin
                     wnum_in = 2'd1; wdata_in[0] = s_ff & t_ff; depth_in = dm1;
                  end
                  fdsa_pkg::OP_MUL, fdsa_pkg::OP_DIV: begin
                     wnum_in = 2'd1; depth_in = dm1; md_go = 1'b1;
                  end
                  fdsa_pkg::OP_DUP: begin
                     wnum_in = 2'd1; waddr_in[0] = depth_ff[SAW-1:0];
                     wdata_in[0] = t_ff; depth_in = depth_ff + DW'(1);
                  end
                  fdsa_pkg::OP_DROP: begin
                     popped_in = t_ff; popped_valid_in = 1'b1; depth_in = dm1;
                  end
                  fdsa_pkg::OP_SWAP: begin
                     wnum_in = 2'd2; waddr_in[0] = dm1[SAW-1:0]; wdata_in[0] = s_ff;
                  end
                  fdsa_pkg::OP_ROT: begin
                     wnum_in = 2'd3; waddr_in[0] = dm3[SAW-1:0]; wdata_in[0] = s_ff;
                  end
                  fdsa_pkg::OP_EQ, fdsa_pkg::OP_GT, fdsa_pkg::OP_LT: begin
                     wnum_in = 2'd1; waddr_in[0] = depth_ff[SAW-1:0];
                     depth_in = depth_ff + DW'(1);
                     if (op_ff == fdsa_pkg::OP_EQ)
                        wdata_in[0] = W'(s_ff == t_ff);
                     else if (op_ff == fdsa_pkg::OP_GT)
                        wdata_in[0] = W'($signed(t_ff) < $signed(s_ff));
                     else
                        wdata_in[0] = W'($signed(s_ff) < $signed(t_ff));
                  end
                  fdsa_pkg::OP_NOT: begin
                     wnum_in = 2'd1; waddr_in[0] = dm1[SAW-1:0];
                     wdata_in[0] = W'(t_ff == '0);
                  end
                  fdsa_pkg::OP_FETCH: begin
                     wnum_in = 2'd1; waddr_in[0] = dm1[SAW-1:0];
                  end
                  fdsa_pkg::OP_STORE: begin
                     mem_we = 1'b1; depth_in = dm2;
                  end
                  default: ;
               endcase
            end
            if (md_go)
               state_in = fdsa_pkg::S_MULDIV;
            else if (exe_status == fdsa_pkg::ST_OK && wnum_in != 2'd0)
               state_in = fdsa_pkg::S_WR0;
            else
               state_in = fdsa_pkg::S_RD_TOP;
            if (exe_status != fdsa_pkg::ST_OK) wnum_in = 2'd0;
         end
         fdsa_pkg::S_MULDIV: begin
            if (md_done) begin
               wdata_in[0] = md_result;
               state_in    = fdsa_pkg::S_WR0;
            end
         end
         fdsa_pkg::S_WR0: begin
            stk_we    = 1'b1;
            stk_waddr = waddr_ff[0];
            stk_wdata = (op_ff == fdsa_pkg::OP_FETCH) ? mem_rdata_ff : wdata_ff[0];
            state_in  = (wnum_ff > 2'd1) ? fdsa_pkg::S_WR1 : fdsa_pkg::S_RD_TOP;
         end
         fdsa_pkg::S_WR1: begin
            stk_we    = 1'b1;
            stk_waddr = waddr_ff[1];
            stk_wdata = wdata_ff[1];
            state_in  = (wnum_ff > 2'd2) ? fdsa_pkg::S_WR2 : fdsa_pkg::S_RD_TOP;
         end
         fdsa_pkg::S_WR2: begin
            stk_we    = 1'b1;
            stk_waddr = waddr_ff[2];
            stk_wdata = wdata_ff[2];
            state_in  = fdsa_pkg::S_RD_TOP;
         end
         fdsa_pkg::S_RD_TOP: begin
            stk_raddr = dm1[SAW-1:0];
            state_in  = fdsa_pkg::S_RESP;
         end
         fdsa_pkg::S_RESP: begin
            state_in = fdsa_pkg::S_IDLE;
         end
         default: state_in = fdsa_pkg::S_IDLE;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fdsa_pkg::S_CLEAR;
         depth_ff <= '0;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         depth_ff <= depth_in;
         clr_ff   <= clr_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      op_ff           <= op_in;
      lit_ff          <= lit_in;
      status_ff       <= status_in;
      t_ff            <= t_in;
      s_ff            <= s_in;
      popped_ff       <= popped_in;
      popped_valid_ff <= popped_valid_in;
      wnum_ff         <= wnum_in;
      waddr_ff        <= waddr_in;
      wdata_ff        <= wdata_in;
   end

   // stack memory, one read and one write port
   always_ff @(posedge clock) begin
      if (stk_we) stk_mem[stk_waddr] <= stk_wdata;
      stk_rdata_ff <= stk_mem[stk_raddr];
   end

   // word memory, one read and one write port
   always_ff @(posedge clock) begin
      if (mem_we) word_mem[mem_waddr] <= mem_wdata;
      mem_rdata_ff <= word_mem[t_ff[AW-1:0]];
   end

   assign busy             = (state_ff != fdsa_pkg::S_IDLE);
   assign rsp_strobe       = (state_ff == fdsa_pkg::S_RESP);
   assign rsp_top_value    = (depth_ff != '0) ? stk_rdata_ff : '0;
   assign rsp_stack_depth  = depth_ff;
   assign rsp_status       = status_ff;
   assign rsp_popped_value = popped_ff;
   assign rsp_popped_valid = popped_valid_ff;

   // a word goes busy the cycle after it is taken
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("accepted word not busy");
   // each result is a single-cycle strobe
   a_strobe_one: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe) else $error("result strobe held");
   // popped value only on a successful drop
   a_pop_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_popped_valid) |-> (rsp_status == fdsa_pkg::ST_OK))
      else $error("pop reported on failed word");
   // depth never exceeds stack size
   a_depth_max: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DW'(STACK_DEPTH)) else $error("stack depth out of range");
   // a failed word leaves the depth unchanged
   a_fail_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fdsa_pkg::S_EXEC && exe_status != fdsa_pkg::ST_OK)
      |=> $stable(depth_ff)) else $error("depth changed on failed word");

endmodule
